/* sv/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// request and response codes, beat payload types of the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_CLEAR      = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } t_req_beat;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_data;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_rsp_beat;

    // memory strobes from the controller to the entry store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_op;

    // per-request outcome handed to the response stage
    typedef struct packed {
        t_status status;
        logic    rd_ok;
    } t_ctrl_res;

endpackage

/* sv/deq_if.sv */
// ----------------------------------------------------------------------------
// deq_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface deq_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/deq_store.sv */
// ----------------------------------------------------------------------------
// deq_store
// entry memory: one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module deq_store #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    parameter int PW         = 8
) (
    input  logic                  i_clk,
    input  deq_pkg::t_mem_op      i_op,
    input  logic [PW-1:0]         i_addr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_op.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// deq_ctrl
// front pointer and occupancy, request decode, memory address generation
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH = 256,
    parameter int PW    = 8,
    parameter int CW    = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  deq_pkg::t_req_beat    i_req,
    output deq_pkg::t_mem_op      o_op,
    output logic [PW-1:0]         o_addr,
    output logic [CW-1:0]         o_count,
    output deq_pkg::t_ctrl_res    o_res
);

    localparam int CMPW = (CW > deq_pkg::INDEX_W) ? CW : deq_pkg::INDEX_W;
    localparam logic [PW:0]   DEPTH_P = (PW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] front_inc, front_dec;
    logic [PW:0]   offset, sum, sum_wrap;
    logic          is_full, is_empty, in_range;

    assign is_full  = (r_count == DEPTH_C);
    assign is_empty = (r_count == '0);
    assign in_range = (CMPW'(i_req.index) < CMPW'(r_count));

    assign front_inc = (r_front == LAST_P) ? '0 : r_front + 1'b1;
    assign front_dec = (r_front == '0) ? LAST_P : r_front - 1'b1;

    // front plus offset stays below twice the depth, one subtract wraps it
    assign offset   = (i_req.req_type == deq_pkg::REQ_READ) ?
                      (PW+1)'(i_req.index) : (PW+1)'(r_count);
    assign sum      = {1'b0, r_front} + offset;
    assign sum_wrap = (sum >= DEPTH_P) ? sum - DEPTH_P : sum;

    always_comb begin
        n_front      = r_front;
        n_count      = r_count;
        o_op         = '0;
        o_addr       = sum_wrap[PW-1:0];
        o_res.status = deq_pkg::ST_OK;
        o_res.rd_ok  = 1'b0;
        unique case (deq_pkg::t_req'(i_req.req_type))
            deq_pkg::REQ_PUSH_BACK: begin
                if (is_full) begin
                    o_res.status = deq_pkg::ST_FULL;
                end else begin
                    o_op.wr_en = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_PUSH_FRONT: begin
                o_addr = front_dec;
                if (is_full) begin
                    o_res.status = deq_pkg::ST_FULL;
                end else begin
                    o_op.wr_en = 1'b1;
                    n_front    = front_dec;
                    n_count    = r_count + 1'b1;
                end
            end
            deq_pkg::REQ_POP_FRONT: begin
                if (is_empty) begin
                    o_res.status = deq_pkg::ST_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::REQ_POP_BACK: begin
                if (is_empty) begin
                    o_res.status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::REQ_READ: begin
                if (!in_range) begin
                    o_res.status = deq_pkg::ST_RANGE;
                end else begin
                    o_op.rd_en  = 1'b1;
                    o_res.rd_ok = 1'b1;
                end
            end
            deq_pkg::REQ_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        // strobes only for a beat actually taken
        o_op.wr_en = o_op.wr_en & i_accept;
        o_op.rd_en = o_op.rd_en & i_accept;
    end

    assign o_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// double-ended queue of data words in a circular buffer of DEPTH entries
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | beat taken when
//  i_req   | in  | req_type, value, index           | valid && ready
//  o_rsp   | out | read_data, entry_count, status   | valid && ready
//
//  one request per cycle sustained while o_rsp is not stalled; each request passes
//  the pending stage, where the entry memory read is registered, then the output register
//  pointer, count and memory write are settled in the cycle the request is taken
//  synchronous active-low reset empties the queue; memory contents are not cleared
//  a stalled o_rsp holds its beat and one more request may wait in the pending stage
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    deq_if.sink   i_req,
    deq_if.source o_rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_req_beat    req;
    deq_pkg::t_mem_op      mem_op;
    deq_pkg::t_ctrl_res    ctrl_res;
    logic [PW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [CW-1:0]         ctrl_count;
    logic                  accept, advance;

    logic                  r_pend_valid;
    deq_pkg::t_ctrl_res    r_pend_res;
    logic [CW-1:0]         r_pend_count;
    logic                  r_out_valid;
    deq_pkg::t_rsp_beat    r_out;

    assign req       = i_req.payload;
    assign advance   = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_pend_valid || advance;
    assign accept    = i_req.valid && i_req.ready;
    assign mem_wdata = DATA_WIDTH'(req.value);

    deq_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .o_op     (mem_op),
        .o_addr   (mem_addr),
        .o_count  (ctrl_count),
        .o_res    (ctrl_res)
    );

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PW         (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_op    (mem_op),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_pend_valid;
            end
            if (accept) begin
                r_pend_valid <= 1'b1;
            end else if (advance) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // memory read data stays put until the next read, which needs a new beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_res   <= ctrl_res;
            r_pend_count <= ctrl_count;
        end
        if (advance && r_pend_valid) begin
            r_out.read_data   <= r_pend_res.rd_ok ? deq_pkg::VALUE_W'(mem_rdata) : '0;
            r_out.entry_count <= deq_pkg::COUNT_W'(r_pend_count);
            r_out.status      <= r_pend_res.status;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

/* sv/deq_checker.sv */
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks on the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = 256
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input deq_pkg::t_rsp_beat i_out
);

    localparam logic [deq_pkg::COUNT_W-1:0] FULL_COUNT = deq_pkg::COUNT_W'(DEPTH);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("stalled result beat changed");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status == deq_pkg::ST_EMPTY |-> i_out.entry_count == '0)
        else $error("pop on empty with nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status == deq_pkg::ST_FULL |-> i_out.entry_count == FULL_COUNT)
        else $error("push dropped while not full");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.read_data != '0 |-> i_out.status == deq_pkg::ST_OK)
        else $error("read data on a failed request");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out       (o_rsp.payload)
);
